@@ design/wwps_pkg.sv @@
// shared constants for the whole-word pattern search block
`default_nettype none
package wwps_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int WIN_DEPTH   = MAX_PATTERN + 2;
  localparam int HIST_DEPTH  = WIN_DEPTH - 1;
  localparam int MAX_TEXT    = 65536;
  localparam int CNT_W       = $clog2(MAX_TEXT + 1);
  localparam int LEN_W       = 4;
  localparam int START_W     = 16;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam logic [1:0] STATUS_SEARCHING = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [1:0] REG_PATTERN_CHARS   = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH  = 2'd1;
  localparam logic [1:0] REG_WHOLE_WORD_ONLY = 2'd2;

  typedef logic [7:0] byte_t;

endpackage
`default_nettype wire

@@ design/whole_word_pattern_search_top.sv @@
// whole-word pattern search: window compare, match tracking and output register
//
// Input channel (in_*): one text byte per request, in_tlast marks the final byte
// of a string. Output channel (out_*): one status result per input byte;
// out_tuser is searching, found or not found at end, out_tdata the 0-based start
// of the first match (zero unless found).
// Configuration (cfg_*): index 0 pattern bytes (first byte lowest), index 1
// pattern length 1..8 in bits 3:0 (0 as 1, 9..15 as 8), index 2 whole-word mode.
// Write only while no byte is in flight.
// The result is registered in the cycle after the input request is taken; one
// byte is taken every cycle while the receiver keeps up, and the two window
// compares sit between the history registers and the output register. A result
// held there leaves the input free if the receiver takes it in the same cycle.
// Once found, the match is reported on every later byte of the string. All
// stream state clears after the byte marked last.
// Reset clears the history, the byte counter, the match flag and the output
// valid; the registers return to pattern 0, length 1, whole-word mode on.
// When the receiver stalls, the result holds and in_tready drops.
`default_nettype none
module whole_word_pattern_search_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] match_start
  output logic [1:0]       out_tuser,  // [1:0] search_status
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata
);

  logic [63:0]                   pattern_r;
  logic [wwps_pkg::LEN_W-1:0]    len_r;
  logic                          whole_word_r;

  wwps_pkg::byte_t               hist_r [wwps_pkg::HIST_DEPTH];
  logic [wwps_pkg::CNT_W-1:0]    bytes_seen_r;
  logic                          match_held_r;
  logic [wwps_pkg::START_W-1:0]  held_start_r;

  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [wwps_pkg::START_W-1:0]  out_start_r;

  wwps_pkg::byte_t               win [wwps_pkg::WIN_DEPTH];
  logic [1:0]                    eq;
  logic [1:0]                    cand_ok;
  logic [wwps_pkg::START_W-1:0]  start [2];
  logic                          active;
  logic                          hit;
  logic [wwps_pkg::START_W-1:0]  hit_start;
  logic                          match_held_nxt;
  logic [wwps_pkg::START_W-1:0]  held_start_nxt;
  logic [1:0]                    out_status_nxt;
  logic [wwps_pkg::START_W-1:0]  out_start_nxt;
  logic [wwps_pkg::LEN_W-1:0]    len_nxt;
  logic                          accept;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_start_r;
  assign out_tuser  = out_status_r;

  // clamp the written length into 1..MAX_PATTERN
  always_comb begin
    len_nxt = cfg_wdata[wwps_pkg::LEN_W-1:0];
    if (len_nxt == '0) begin
      len_nxt = wwps_pkg::LEN_W'(1);
    end else if (len_nxt > wwps_pkg::LEN_W'(wwps_pkg::MAX_PATTERN)) begin
      len_nxt = wwps_pkg::LEN_W'(wwps_pkg::MAX_PATTERN);
    end
  end

  always_comb begin
    logic [3:0]                 idx;
    logic [3:0]                 bidx;
    logic [wwps_pkg::CNT_W:0]   need;
    logic [wwps_pkg::CNT_W:0]   have;
    logic                       tail_ok;
    logic                       head_ok;
    win[0] = in_tdata;
    for (int k = 1; k < wwps_pkg::WIN_DEPTH; k++) begin
      win[k] = hist_r[k-1];
    end
    active = !match_held_r && (bytes_seen_r < wwps_pkg::CNT_W'(wwps_pkg::MAX_TEXT));
    have   = {1'b0, bytes_seen_r} + (wwps_pkg::CNT_W+1)'(1);
    // candidate 0 ends at the newest byte, candidate 1 one byte earlier
    for (int o = 0; o < 2; o++) begin
      eq[o] = 1'b1;
      for (int j = 0; j < wwps_pkg::MAX_PATTERN; j++) begin
        idx = 4'(o) + len_r - 4'(j + 1);
        if ((4'(j) < len_r) && (win[idx] != pattern_r[8*j +: 8])) begin
          eq[o] = 1'b0;
        end
      end
      need     = (wwps_pkg::CNT_W+1)'(len_r) + (wwps_pkg::CNT_W+1)'(o);
      start[o] = wwps_pkg::START_W'(have - need);
      bidx     = 4'(o) + len_r;
      head_ok  = (start[o] == '0) || (win[bidx] == wwps_pkg::SPACE_BYTE);
      tail_ok  = (o == 0) || (in_tdata == wwps_pkg::SPACE_BYTE);
      cand_ok[o] = active && (have >= need) && eq[o] &&
                   (!whole_word_r || (head_ok && tail_ok));
    end
    hit       = 1'b0;
    hit_start = '0;
    if (whole_word_r) begin
      if (cand_ok[1]) begin
        hit       = 1'b1;
        hit_start = start[1];
      end else if (in_tlast && cand_ok[0]) begin
        hit       = 1'b1;
        hit_start = start[0];
      end
    end else if (cand_ok[0]) begin
      hit       = 1'b1;
      hit_start = start[0];
    end
    match_held_nxt = match_held_r || hit;
    held_start_nxt = hit ? hit_start : held_start_r;
    if (match_held_nxt) begin
      out_status_nxt = wwps_pkg::STATUS_FOUND;
      out_start_nxt  = held_start_nxt;
    end else begin
      out_status_nxt = in_tlast ? wwps_pkg::STATUS_NOT_FOUND : wwps_pkg::STATUS_SEARCHING;
      out_start_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r    <= '0;
      len_r        <= wwps_pkg::LEN_W'(1);
      whole_word_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wwps_pkg::REG_PATTERN_CHARS:   pattern_r    <= cfg_wdata;
        wwps_pkg::REG_PATTERN_LENGTH:  len_r        <= len_nxt;
        wwps_pkg::REG_WHOLE_WORD_ONLY: whole_word_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < wwps_pkg::HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
      bytes_seen_r <= '0;
      match_held_r <= 1'b0;
      held_start_r <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        for (int k = 0; k < wwps_pkg::HIST_DEPTH; k++) begin
          hist_r[k] <= '0;
        end
        bytes_seen_r <= '0;
        match_held_r <= 1'b0;
        held_start_r <= '0;
      end else begin
        for (int k = 0; k < wwps_pkg::HIST_DEPTH; k++) begin
          hist_r[k] <= win[k];
        end
        if (bytes_seen_r < wwps_pkg::CNT_W'(wwps_pkg::MAX_TEXT)) begin
          bytes_seen_r <= bytes_seen_r + wwps_pkg::CNT_W'(1);
        end
        match_held_r <= match_held_nxt;
        held_start_r <= held_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_start_r  <= out_start_nxt;
    end
  end

  // the last byte of a string leaves no stream state behind
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> (bytes_seen_r == '0) && !match_held_r)
    else $error("stream state not cleared after last byte");

  // a held match is reported on every later byte of the string
  a_held_reports: assert property (@(posedge clk) disable iff (!rst_n)
    accept && match_held_r |=> (out_status_r == wwps_pkg::STATUS_FOUND) &&
                               (out_start_r == $past(held_start_r)))
    else $error("held match not reported");

  // start index only carries a value with a found status
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != wwps_pkg::STATUS_FOUND) |-> out_start_r == '0)
    else $error("nonzero start without a match");

  // byte counter saturates
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= wwps_pkg::CNT_W'(wwps_pkg::MAX_TEXT))
    else $error("byte counter past saturation");

  // a match never reports a start beyond the bytes seen so far
  a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match_held_r |-> {1'b0, held_start_r} < bytes_seen_r)
    else $error("match start beyond bytes seen");

endmodule
`default_nettype wire

@@ tb/whole_word_pattern_search_top_tb.sv @@
// testbench for the whole-word pattern search block: directed strings and random traffic
`timescale 1ns / 100ps
module whole_word_pattern_search_top_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BYTES = 1600;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [wwps_pkg::START_W-1:0] start;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_wdata;

  // search state mirrored from the block
  logic [63:0]                pat_bytes;
  logic [wwps_pkg::LEN_W-1:0] pat_len;
  logic                       word_mode;
  wwps_pkg::byte_t            text_win [wwps_pkg::WIN_DEPTH];
  int unsigned                text_pos;
  bit                         hit_seen;
  int unsigned                hit_pos;

  status_t         pending_status[$];
  wwps_pkg::byte_t text_buf[$];
  int              mismatches;
  int              quiet_cycles;
  int              burst_left;
  bit              tx_gapless;
  rx_mode_t        rx_mode;
  int              hold_left;
  int              rx_tick;

  whole_word_pattern_search_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_text();
    for (int k = 0; k < wwps_pkg::WIN_DEPTH; k++) text_win[k] = 8'h00;
    text_pos = 0;
    hit_seen = 1'b0;
    hit_pos = 0;
  endfunction

  function automatic int unsigned active_len();
    if (pat_len == 0) return 1;
    if (pat_len > wwps_pkg::MAX_PATTERN) return wwps_pkg::MAX_PATTERN;
    return 32'(pat_len);
  endfunction

  // candidate whose last byte sits off positions back in the window
  function automatic bit try_match(int unsigned len, int unsigned off, int unsigned n,
                                   bit tail_ok);
    int unsigned s;
    int unsigned j;
    if (n + 1 < len + off) return 1'b0;
    s = n + 1 - len - off;
    if (s > 32'hFFFF) return 1'b0;
    for (j = 0; j < len; j++)
      if (text_win[off + len - 1 - j] != pat_bytes[8*j +: 8]) return 1'b0;
    if (word_mode) begin
      if (!tail_ok) return 1'b0;
      if (s != 0 && text_win[off + len] != wwps_pkg::SPACE_BYTE) return 1'b0;
    end
    hit_seen = 1'b1;
    hit_pos = s;
    return 1'b1;
  endfunction

  function automatic void search_byte(wwps_pkg::byte_t b, bit last);
    int unsigned n;
    int unsigned len;
    status_t r;
    n = text_pos;
    for (int k = wwps_pkg::WIN_DEPTH - 1; k > 0; k--) text_win[k] = text_win[k-1];
    text_win[0] = b;
    if (!hit_seen && n < wwps_pkg::MAX_TEXT) begin
      len = active_len();
      if (word_mode) begin
        // the byte just taken closes a candidate one back, or the string end closes one here
        if (!try_match(len, 1, n, b == wwps_pkg::SPACE_BYTE) && last)
          void'(try_match(len, 0, n, 1'b1));
      end else begin
        void'(try_match(len, 0, n, 1'b1));
      end
    end
    if (text_pos < wwps_pkg::MAX_TEXT) text_pos++;
    if (hit_seen) begin
      r.status = wwps_pkg::STATUS_FOUND;
      r.start = hit_pos[wwps_pkg::START_W-1:0];
    end else begin
      r.status = last ? wwps_pkg::STATUS_NOT_FOUND : wwps_pkg::STATUS_SEARCHING;
      r.start = '0;
    end
    pending_status.push_back(r);
    if (last) clear_text();
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic pace();
    if (tx_gapless) return;
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_byte(input wwps_pkg::byte_t b, input bit last);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    search_byte(b, last);
    pace();
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wwps_pkg::REG_PATTERN_CHARS:   pat_bytes = val;
      wwps_pkg::REG_PATTERN_LENGTH:  pat_len = val[wwps_pkg::LEN_W-1:0];
      wwps_pkg::REG_WHOLE_WORD_ONLY: word_mode = val[0];
      default: ;
    endcase
  endtask

  // words, spaces, pattern copies and random bytes, cut at a random length
  task automatic make_text();
    int target;
    int len;
    int k;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
    len = active_len();
    while (text_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (k = 0; k < len; k++) text_buf.push_back(pat_bytes[8*k +: 8]);
        3, 4:    text_buf.push_back(wwps_pkg::SPACE_BYTE);
        5, 6, 7, 8:
          repeat ($urandom_range(1, 3))
            text_buf.push_back(wwps_pkg::byte_t'(8'h61 + $urandom_range(0, 2)));
        default: text_buf.push_back(wwps_pkg::byte_t'($urandom_range(0, 255)));
      endcase
    end
    while (text_buf.size() > target) void'(text_buf.pop_back());
  endtask

  task automatic test_reset_defaults();
    // reset pattern is a single zero byte in whole-word mode; zero is an ordinary byte
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b1);
    settle();
  endtask

  task automatic test_whole_word_bounds();
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'h6261);
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(wwps_pkg::REG_WHOLE_WORD_ONLY, 64'd1);
    push_str("xab ab");
    send_text();
    settle();
  endtask

  task automatic test_plain_reporting();
    // found on the second byte, held for the rest of the string
    write_reg(wwps_pkg::REG_WHOLE_WORD_ONLY, 64'hFFFF_FFFF_FFFF_FFFE);
    push_str("abab");
    send_text();
    settle();
  endtask

  task automatic test_short_text();
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'd8);
    repeat (3) text_buf.push_back(8'hFF);
    send_text();
    settle();
  endtask

  task automatic test_length_clamp();
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'hF);
    repeat (8) text_buf.push_back(8'hFF);
    send_text();
    settle();
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'h71);
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    push_str("zq");
    send_text();
    settle();
  endtask

  task automatic test_write_mid_string();
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'h6B);
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    settle();
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'h63);
    send_byte(8'h63, 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    tx_gapless = 1'b1;
    write_reg(wwps_pkg::REG_PATTERN_CHARS, 64'h6162);
    write_reg(wwps_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(wwps_pkg::REG_WHOLE_WORD_ONLY, 64'd1);
    hold_left = 80;
    while (text_buf.size() < 40) make_text();
    send_text();
    settle();
    tx_gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent;
    logic [63:0] pat;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      settle();
      for (int k = 0; k < 8; k++)
        case ($urandom_range(0, 7))
          0:       pat[8*k +: 8] = 8'($urandom_range(0, 255));
          1:       pat[8*k +: 8] = wwps_pkg::SPACE_BYTE;
          default: pat[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 2));
        endcase
      write_reg(wwps_pkg::REG_PATTERN_CHARS, pat);
      write_reg(wwps_pkg::REG_PATTERN_LENGTH,
                64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 8)));
      write_reg(wwps_pkg::REG_WHOLE_WORD_ONLY, ($urandom_range(0, 4) < 3) ? 64'd1 : 64'd0);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      tx_gapless = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 12)) begin
        make_text();
        sent += text_buf.size();
        send_text();
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default:   out_tready <= (rx_tick % 11) < 7;
      endcase
    end
  end

  always @(posedge clk) begin : check_status
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, got status %0d start %0d",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_status.pop_front();
        if (out_tuser !== want.status) begin
          mismatches++;
          $display("%0t status mismatch: expected %0d, got %0d", $time, want.status, out_tuser);
        end
        if (out_tdata !== want.start) begin
          mismatches++;
          $display("%0t match_start mismatch: expected %0d, got %0d",
                   $time, want.start, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = wwps_pkg::REG_PATTERN_CHARS;
    cfg_wdata = '0;
    mismatches = 0;
    quiet_cycles = 0;
    burst_left = 0;
    tx_gapless = 1'b0;
    rx_mode = RX_RANDOM;
    hold_left = 0;
    rx_tick = 0;
    pat_bytes = '0;
    pat_len = 1;
    word_mode = 1'b1;
    clear_text();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_whole_word_bounds();
    test_plain_reporting();
    test_short_text();
    test_length_clamp();
    test_write_mid_string();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
